[hw/rtl/mdbc_pkg.sv]
// Package for the markup delimiter balance checker.
// Holds the stack depth, derived widths, symbol codes and the byte decoder.
// No dependencies.
package mdbc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic [1:0] sym_t;

    localparam sym_t SYM_NONE  = 2'd0;
    localparam sym_t SYM_UNDER = 2'd1;
    localparam sym_t SYM_STAR  = 2'd2;
    localparam sym_t SYM_SLASH = 2'd3;

    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    function automatic sym_t sym_code(input logic [7:0] ch);
        sym_t code;
        code = SYM_NONE;
        if (ch == CHAR_UNDER) code = SYM_UNDER;
        if (ch == CHAR_STAR)  code = SYM_STAR;
        if (ch == CHAR_SLASH) code = SYM_SLASH;
        return code;
    endfunction

endpackage

[hw/rtl/markup_delimiter_balance_checker.sv]
// Markup delimiter balance checker, top level.
// Depends on mdbc_pkg; checked by mdbc_checker (bound in its own file).
//
// Usage:
//   Slave channel: one text byte per item in s_tdata, s_tlast marks the
//   last byte of a text. Master channel: one verdict item per text.
//   Underscore, asterisk and slash toggle entries on a symbol stack: a
//   delimiter equal to the top pops it, any other delimiter is pushed.
//   Throughput: one byte per cycle while s_tready is high. The top of
//   stack sits in a register; the entry below it is prefetched from the
//   stack RAM every cycle, with a bypass when the same entry was written
//   in the cycle before. Each verdict is registered into the output buffer.
//   A push onto a full stack is dropped and sets a sticky overflow flag,
//   which forces an error verdict. Stack and flag clear after each verdict.
//   Stalls: verdicts go through a two-entry output buffer (output register
//   plus skid), so bytes keep flowing while a verdict waits; s_tready drops
//   only when both entries hold verdicts.
//   Reset (aresetn low, synchronous) empties the stack, clears the flag and
//   drops m_tvalid. The stack RAM needs no clearing pass.
module markup_delimiter_balance_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] balanced, [1] overflowed, [7:2] zero
);
    import mdbc_pkg::*;

    logic [1:0] stack_mem [STACK_DEPTH];

    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_after;
    logic              ovf_reg, ovf_next, ovf_after;
    sym_t              top_reg, top_next;
    sym_t              rd_data_reg;
    logic              fwd_reg, fwd_next;
    sym_t              fwd_data_reg;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              mem_we;

    logic       accept, is_delim, same_top, do_pop, do_push, do_ovf, done;
    sym_t       code, below;
    logic [1:0] verdict;

    // output buffer: head register and skid register
    logic       out_valid_reg, skid_valid_reg;
    logic [1:0] out_data_reg, skid_data_reg;
    logic       head_free;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign done     = accept && s_tlast;

    always_comb begin
        code     = sym_code(s_tdata);
        is_delim = (code != SYM_NONE);
        same_top = (cnt_reg != '0) && (top_reg == code);
        do_pop   = accept && is_delim && same_top;
        do_push  = accept && is_delim && !same_top && (cnt_reg != CNT_W'(STACK_DEPTH));
        do_ovf   = accept && is_delim && !same_top && (cnt_reg == CNT_W'(STACK_DEPTH));
        below    = fwd_reg ? fwd_data_reg : rd_data_reg;

        if (do_pop)       cnt_after = cnt_reg - CNT_W'(1);
        else if (do_push) cnt_after = cnt_reg + CNT_W'(1);
        else              cnt_after = cnt_reg;
        ovf_after = ovf_reg || do_ovf;

        verdict  = {ovf_after, (cnt_after == '0) && !ovf_after};
        cnt_next = done ? '0 : cnt_after;
        ovf_next = done ? 1'b0 : ovf_after;

        if (do_push)     top_next = code;
        else if (do_pop) top_next = below;
        else             top_next = top_reg;

        // old top spills into the RAM on a push onto a non-empty stack
        mem_we  = do_push && (cnt_reg != '0);
        wr_addr = ADDR_W'(cnt_reg - CNT_W'(1));
        // prefetch the entry under the next top
        rd_addr  = ADDR_W'(cnt_next - CNT_W'(2));
        fwd_next = mem_we && (wr_addr == rd_addr);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= top_reg;
        end
        rd_data_reg  <= stack_mem[rd_addr];
        fwd_data_reg <= top_reg;
        top_reg      <= top_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            fwd_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            fwd_reg <= fwd_next;
        end
    end

    assign head_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (head_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= done;
            end else begin
                out_valid_reg  <= done;
            end
        end else if (done) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_free) begin
            if (skid_valid_reg) begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= verdict;
            end else begin
                out_data_reg  <= verdict;
            end
        end else if (done) begin
            skid_data_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_data_reg};

endmodule

[hw/rtl/mdbc_checker.sv]
// Port-level checks for the markup delimiter balance checker.
// Bound to markup_delimiter_balance_checker; no package dependency.
module mdbc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled verdict holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed while stalled");

    // a verdict with overflow can never read as balanced; pad bits stay zero
    a_verdict_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[7:2] == 6'b0))
        else $error("inconsistent verdict");

    // an empty output only fills from a last byte taken the cycle before
    a_verdict_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("verdict without end of text");

    // input backpressure only while a verdict is pending
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending verdict");

endmodule

bind markup_delimiter_balance_checker mdbc_checker u_mdbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
